/* sv/bb3_pkg.sv */
// Shared types, constants and register codes for the 3x3 box blur stream.
package bb3_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int MAX_COLS    = 1024;
  localparam int MAX_ROWS    = 4096;
  localparam int ROW_W       = $clog2(MAX_ROWS + 2);

  localparam int ROW_CFG_W  = 13;
  localparam int COL_CFG_W  = 11;
  localparam int CFG_DATA_W = 13;
  localparam int ROW_RESET  = 256;
  localparam int COL_RESET  = 256;

  localparam int MQ_DEPTH  = 4;
  localparam int OQ_DEPTH  = 4;
  localparam int MQ_CNT_W  = $clog2(MQ_DEPTH + 1);
  localparam int OQ_CNT_W  = $clog2(OQ_DEPTH + 1);

  localparam int DIVISOR    = 9;
  localparam int ROUND_BIAS = 4;
  localparam int SUM_W      = SAMPLE_BITS + 4;
  localparam int DIV_SHIFT  = SUM_W + 4;
  localparam int RECIP_W    = SUM_W + 1;
  localparam logic [RECIP_W-1:0] RECIP9 =
    RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(DIVISOR - 1)) / 64'(DIVISOR));

  typedef enum logic [0:0] {
    FUNC_SAMPLE = 1'b0,
    FUNC_FLUSH  = 1'b1
  } func_t;

  typedef enum logic [0:0] {
    CFG_ROW_COUNT = 1'b0,
    CFG_COL_COUNT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    func_t                  func;
    logic [SAMPLE_BITS-1:0] sample_in;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample_out;
    logic                   last_of_frame;
  } out_item_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] top;
    logic [SAMPLE_BITS-1:0] mid;
    logic [SAMPLE_BITS-1:0] bot;
    logic                   first_col;
    logic                   last_col;
    logic                   interior;
    logic                   emit;
    logic                   last;
  } job_t;

endpackage

/* sv/box_blur_3x3_stream.sv */
// Top level of the streaming 3x3 box blur.
// Samples arrive in raster order and one item is taken on every clock while the
// result side keeps up; each result is the sample one row plus one column behind
// the input; after the transfer that completes it, it goes to the result port
// by way of the registered line store read, the middle queue, the window stage,
// the sum stage and the result queue. Interior samples get the rounded mean of
// their 3x3 neighbourhood, border samples pass through. After the last sample of
// a frame, col_count + 1 flush items (or further samples, whose values are
// dropped) drain the remaining results, and the final one carries last_of_frame.
// A flush that arrives before the frame's samples are all in is dropped. The line
// store is a two-row memory with no clearing pass; writing either register
// restarts the frame.
module box_blur_3x3_stream #(
  parameter int MAX_COLS = bb3_pkg::MAX_COLS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  bb3_pkg::in_item_t               in_item,
  input  logic                            pop,
  output logic                            empty,
  output bb3_pkg::out_item_t              out_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  bb3_pkg::cfg_idx_t               cfg_index,
  input  logic [bb3_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic                          job_valid;
  bb3_pkg::job_t                 job;
  logic                          mq_empty;
  logic                          mq_pop;
  logic [bb3_pkg::MQ_CNT_W-1:0]  mq_count;
  bb3_pkg::job_t                 mq_job;
  logic                          oq_push;
  bb3_pkg::out_item_t            oq_item;
  logic [bb3_pkg::OQ_CNT_W-1:0]  oq_count;

  assign cfg_ready = 1'b1;

  bb3_front #(
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mq_count  (mq_count),
    .job_valid (job_valid),
    .job       (job)
  );

  bb3_fifo #(
    .WIDTH ($bits(bb3_pkg::job_t)),
    .DEPTH (bb3_pkg::MQ_DEPTH)
  ) u_mid_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_valid),
    .wdata (job),
    .pop   (mq_pop),
    .rdata (mq_job),
    .empty (mq_empty),
    .count (mq_count)
  );

  bb3_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .mq_empty (mq_empty),
    .mq_job   (mq_job),
    .mq_pop   (mq_pop),
    .oq_count (oq_count),
    .oq_push  (oq_push),
    .oq_item  (oq_item)
  );

  bb3_fifo #(
    .WIDTH ($bits(bb3_pkg::out_item_t)),
    .DEPTH (bb3_pkg::OQ_DEPTH)
  ) u_out_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .wdata (oq_item),
    .pop   (pop),
    .rdata (out_item),
    .empty (empty),
    .count (oq_count)
  );

endmodule

/* sv/bb3_fifo.sv */
// Small register-based queue used between the front, the back and the result port.
module bb3_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             push_ok;
  logic             pop_ok;

  assign push_ok = push && (count_r != CW'(DEPTH));
  assign pop_ok  = pop && (count_r != '0);
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        count_r <= count_r + 1'b1;
      end else if (pop_ok && !push_ok) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

/* sv/bb3_front.sv */
// Front end: configuration, raster position tracking and the two-row line store.
module bb3_front #(
  parameter int MAX_COLS = bb3_pkg::MAX_COLS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            push,
  output logic                            full,
  input  bb3_pkg::in_item_t               in_item,
  input  logic                            cfg_valid,
  input  bb3_pkg::cfg_idx_t               cfg_index,
  input  logic [bb3_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [bb3_pkg::MQ_CNT_W-1:0]    mq_count,
  output logic                            job_valid,
  output bb3_pkg::job_t                   job
);

  localparam int SB        = bb3_pkg::SAMPLE_BITS;
  localparam int ROW_W     = bb3_pkg::ROW_W;
  localparam int CW        = $clog2(MAX_COLS + 1);
  localparam int AW        = $clog2(MAX_COLS);
  localparam int POS_W     = $clog2((bb3_pkg::MAX_ROWS + 1) * MAX_COLS + 1);
  localparam int COLS_RST  = (bb3_pkg::COL_RESET > MAX_COLS) ? MAX_COLS : bb3_pkg::COL_RESET;
  localparam int TOTAL_RST = bb3_pkg::ROW_RESET * COLS_RST;
  localparam int TPC_RST   = TOTAL_RST + COLS_RST;

  logic [ROW_W-1:0]                  rows_r;
  logic [CW-1:0]                     cols_r;
  logic [POS_W-1:0]                  total_r;
  logic [POS_W-1:0]                  tpc_r;
  logic [ROW_W-1:0]                  rows_nxt;
  logic [CW-1:0]                     cols_nxt;
  logic [ROW_W+CW-1:0]               area;
  logic [POS_W-1:0]                  total_nxt;
  logic [POS_W-1:0]                  tpc_nxt;
  logic [bb3_pkg::ROW_CFG_W-1:0]     row_raw;
  logic [bb3_pkg::COL_CFG_W-1:0]     col_raw;

  logic [ROW_W-1:0]                  row_r;
  logic [CW-1:0]                     col_r;
  logic [POS_W-1:0]                  pos_r;
  logic [ROW_W-1:0]                  row_nxt;
  logic [CW-1:0]                     col_nxt;
  logic [POS_W-1:0]                  pos_nxt;
  logic [CW-1:0]                     col_inc;

  logic                              accept;
  logic                              draining;
  logic                              proceed;
  logic                              at_last;
  logic [bb3_pkg::MQ_CNT_W:0]        mq_load;

  logic [SB-1:0]                     mem [2 * (2 ** AW)];
  logic [AW:0]                       addr_top;
  logic [AW:0]                       addr_mid;
  logic [SB-1:0]                     top_rd_r;
  logic [SB-1:0]                     mid_rd_r;

  logic                              job_v_r;
  logic [SB-1:0]                     bot_r;
  logic                              first_col_r;
  logic                              last_col_r;
  logic                              interior_r;
  logic                              emit_r;
  logic                              last_r;

  assign row_raw = cfg_data[bb3_pkg::ROW_CFG_W-1:0];
  assign col_raw = cfg_data[bb3_pkg::COL_CFG_W-1:0];

  always_comb begin
    rows_nxt = rows_r;
    cols_nxt = cols_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        bb3_pkg::CFG_ROW_COUNT: begin
          if (row_raw == '0) begin
            rows_nxt = ROW_W'(1);
          end else if (32'(row_raw) > 32'(bb3_pkg::MAX_ROWS)) begin
            rows_nxt = ROW_W'(bb3_pkg::MAX_ROWS);
          end else begin
            rows_nxt = ROW_W'(row_raw);
          end
        end
        bb3_pkg::CFG_COL_COUNT: begin
          if (col_raw == '0) begin
            cols_nxt = CW'(1);
          end else if (32'(col_raw) > 32'(MAX_COLS)) begin
            cols_nxt = CW'(MAX_COLS);
          end else begin
            cols_nxt = CW'(col_raw);
          end
        end
      endcase
    end
  end

  assign area      = (ROW_W+CW)'(rows_nxt) * (ROW_W+CW)'(cols_nxt);
  assign total_nxt = POS_W'(area);
  assign tpc_nxt   = total_nxt + POS_W'(cols_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= ROW_W'(bb3_pkg::ROW_RESET);
      cols_r  <= CW'(COLS_RST);
      total_r <= POS_W'(TOTAL_RST);
      tpc_r   <= POS_W'(TPC_RST);
    end else if (cfg_valid) begin
      rows_r  <= rows_nxt;
      cols_r  <= cols_nxt;
      total_r <= total_nxt;
      tpc_r   <= tpc_nxt;
    end
  end

  // Room is reserved for the item whose line store read is still in flight.
  assign mq_load  = {1'b0, mq_count} + {{bb3_pkg::MQ_CNT_W{1'b0}}, job_v_r};
  assign full     = (mq_load >= (bb3_pkg::MQ_CNT_W+1)'(bb3_pkg::MQ_DEPTH));
  assign accept   = push && !full;
  assign draining = (pos_r >= total_r);
  assign proceed  = accept && !((in_item.func == bb3_pkg::FUNC_FLUSH) && !draining);
  assign at_last  = (pos_r == tpc_r);
  assign col_inc  = col_r + 1'b1;

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    pos_nxt = pos_r;
    if (cfg_valid) begin
      row_nxt = '0;
      col_nxt = '0;
      pos_nxt = '0;
    end else if (proceed) begin
      if (at_last) begin
        row_nxt = '0;
        col_nxt = '0;
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_r + 1'b1;
        if (col_inc >= cols_r) begin
          col_nxt = '0;
          row_nxt = row_r + 1'b1;
        end else begin
          col_nxt = col_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r   <= '0;
      col_r   <= '0;
      pos_r   <= '0;
      job_v_r <= 1'b0;
    end else begin
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      pos_r   <= pos_nxt;
      job_v_r <= proceed;
    end
  end

  assign addr_top = {row_r[0], col_r[AW-1:0]};
  assign addr_mid = {~row_r[0], col_r[AW-1:0]};

  always_ff @(posedge clk) begin
    if (proceed) begin
      top_rd_r <= mem[addr_top];
      mid_rd_r <= mem[addr_mid];
      if (!draining) begin
        mem[addr_top] <= in_item.sample_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proceed) begin
      bot_r       <= draining ? '0 : in_item.sample_in;
      first_col_r <= (col_r == '0);
      last_col_r  <= (col_r == cols_r - 1'b1);
      interior_r  <= (row_r >= ROW_W'(2)) && (row_r < rows_r) && (col_r >= CW'(2));
      emit_r      <= (pos_r > POS_W'(cols_r));
      last_r      <= at_last;
    end
  end

  assign job_valid = job_v_r;

  always_comb begin
    job.top       = top_rd_r;
    job.mid       = mid_rd_r;
    job.bot       = bot_r;
    job.first_col = first_col_r;
    job.last_col  = last_col_r;
    job.interior  = interior_r;
    job.emit      = emit_r;
    job.last      = last_r;
  end

endmodule

/* sv/bb3_back.sv */
// Back end: 3x3 window, rounded mean by nine and result selection.
module bb3_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          mq_empty,
  input  bb3_pkg::job_t                 mq_job,
  output logic                          mq_pop,
  input  logic [bb3_pkg::OQ_CNT_W-1:0]  oq_count,
  output logic                          oq_push,
  output bb3_pkg::out_item_t            oq_item
);

  localparam int SB     = bb3_pkg::SAMPLE_BITS;
  localparam int SUM_W  = bb3_pkg::SUM_W;
  localparam int PROD_W = bb3_pkg::SUM_W + bb3_pkg::RECIP_W;

  logic [SB-1:0]               win_r [3][3];
  logic [SB-1:0]               tail_r;
  logic                        take;
  logic [bb3_pkg::OQ_CNT_W:0]  oq_load;

  logic                        s1_v_r;
  logic                        s1_last_r;
  logic                        s1_interior_r;
  logic [SB-1:0]               s1_pass_r;

  logic                        s2_v_r;
  logic                        s2_last_r;
  logic                        s2_interior_r;
  logic [SB-1:0]               s2_pass_r;
  logic [SUM_W-1:0]            s2_sum_r;

  logic [SUM_W-1:0]            win_sum;
  logic [PROD_W-1:0]           prod;
  logic [SB-1:0]               mean;

  // Results still in the pipeline have a slot held for them in the result queue.
  assign oq_load = {1'b0, oq_count}
                 + {{bb3_pkg::OQ_CNT_W{1'b0}}, s1_v_r}
                 + {{bb3_pkg::OQ_CNT_W{1'b0}}, s2_v_r};
  assign take    = !mq_empty && (oq_load < (bb3_pkg::OQ_CNT_W+1)'(bb3_pkg::OQ_DEPTH));
  assign mq_pop  = take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else if (take) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i][0] <= win_r[i][1];
        win_r[i][1] <= win_r[i][2];
      end
      win_r[0][2] <= mq_job.top;
      win_r[1][2] <= mq_job.mid;
      win_r[2][2] <= mq_job.bot;
    end
  end

  // At the start of a row the border value is the previous row's last sample.
  always_ff @(posedge clk) begin
    if (take) begin
      if (mq_job.last_col) begin
        tail_r <= mq_job.mid;
      end
      s1_last_r     <= mq_job.last;
      s1_interior_r <= mq_job.interior;
      s1_pass_r     <= mq_job.first_col ? tail_r : win_r[1][2];
    end
  end

  always_comb begin
    win_sum = SUM_W'(bb3_pkg::ROUND_BIAS);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        win_sum = win_sum + SUM_W'(win_r[i][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      s2_sum_r      <= win_sum;
      s2_last_r     <= s1_last_r;
      s2_interior_r <= s1_interior_r;
      s2_pass_r     <= s1_pass_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= take && mq_job.emit;
      s2_v_r <= s1_v_r;
    end
  end

  assign prod = PROD_W'(s2_sum_r) * PROD_W'(bb3_pkg::RECIP9);
  assign mean = prod[bb3_pkg::DIV_SHIFT +: SB];

  assign oq_push = s2_v_r;

  always_comb begin
    oq_item.sample_out    = s2_interior_r ? mean : s2_pass_r;
    oq_item.last_of_frame = s2_last_r;
  end

endmodule

/* sv/bb3_checker.sv */
// Port-level checks for the box blur stream, bound to the top level.
module bb3_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               push,
  input logic               full,
  input logic               pop,
  input logic               empty,
  input bb3_pkg::out_item_t out_item
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("Reset did not leave both queues able to transfer.");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_item))
    else $error("A waiting result changed before its transfer.");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(empty) |-> $past(rst_n, 4))
    else $error("A result appeared sooner after reset than the pipeline allows.");

  a_full_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
    !full && !push |=> !full)
    else $error("The input side became full without an input transfer.");

endmodule

bind box_blur_3x3_stream bb3_checker u_bb3_checker (.*);
